@@ design/m3inv_pkg.sv @@
package m3inv_pkg;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
	} mat_t;

	typedef struct packed {
		logic signed [31:0] inv00;
		logic signed [31:0] inv01;
		logic signed [31:0] inv02;
		logic signed [31:0] inv10;
		logic signed [31:0] inv11;
		logic signed [31:0] inv12;
		logic signed [31:0] inv20;
		logic signed [31:0] inv21;
		logic signed [31:0] inv22;
		logic signed [51:0] determinant;
		logic               singular;
		logic               saturated;
	} inv_t;

	localparam int ELEM_W = 16;
	localparam int PROD_W = 32;
	localparam int COF_W  = 33;
	localparam int TRI_W  = 49;
	localparam int DET_W  = 52;
	localparam int DMAG_W = 48;
	localparam int DIV_W  = 49;
	localparam int REM_W  = 62;
	localparam int Q_W    = 33;
	localparam int QSHIFT = 28;

	// cofactor k = e[PA]*e[PB] - e[PC]*e[PD], elements numbered row*3+col
	localparam int PA [9] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
	localparam int PB [9] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
	localparam int PC [9] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
	localparam int PD [9] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

	localparam logic [Q_W-1:0] POS_MAX = 33'h0_7FFF_FFFF;
	localparam logic [Q_W-1:0] NEG_MAX = 33'h0_8000_0000;

endpackage

@@ design/matrix3_inverse_adjugate.sv @@
// channel  | valid      | stall      | payload
// ---------+------------+------------+---------------------------
// matrix   | mat_valid  | mat_stall  | mat (mat_t, nine Q4.12)
// inverse  | inv_valid  | inv_stall  | inv (inv_t, Q16.16 + det)
//
// One matrix per cycle while the output is not stalled; stages: products, cofactors, row-0 terms,
// determinant sum, divider setup, 33 restoring quotient stages, output.
// The 33 quotient stages (one bit each, nine lanes) set the depth.
// Reset clears only the valid bits. A stalled output freezes the whole
// pipeline, so mat_stall follows inv_valid & inv_stall.
module matrix3_inverse_adjugate
	import m3inv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic mat_valid,
	output logic mat_stall,
	input  mat_t mat,
	output logic inv_valid,
	input  logic inv_stall,
	output inv_t inv
);

	localparam int NDIV = Q_W;

	logic adv;
	logic signed [ELEM_W-1:0] e [9];

	logic [3:0] vld_q;
	logic signed [PROD_W-1:0] p_s1 [18];
	logic signed [ELEM_W-1:0] r0_s1 [3];
	logic signed [COF_W-1:0]  cof_s2 [9];
	logic signed [ELEM_W-1:0] r0_s2 [3];
	logic signed [TRI_W-1:0]  t_s3 [3];
	logic signed [COF_W-1:0]  cof_s3 [9];
	logic signed [DET_W-1:0]  det_s4;
	logic signed [COF_W-1:0]  cof_s4 [9];

	// divider pipe, index 0 is the setup stage
	logic [NDIV:0]              dv_vld_s;
	logic [DIV_W-1:0]           dv_d_s   [NDIV+1];
	logic signed [DET_W-1:0]    dv_det_s [NDIV+1];
	logic                       dv_sng_s [NDIV+1];
	logic [REM_W-1:0]           dv_rem_s [NDIV+1][9];
	logic [Q_W-1:0]             dv_q_s   [NDIV+1][9];
	logic                       dv_ovf_s [NDIV+1][9];
	logic                       dv_neg_s [NDIV+1][9];

	logic out_valid_q;
	inv_t out_q;

	assign adv       = !(out_valid_q && inv_stall);
	assign mat_stall = !adv;
	assign inv_valid = out_valid_q;
	assign inv       = out_q;

	assign e[0] = mat.m00;
	assign e[1] = mat.m01;
	assign e[2] = mat.m02;
	assign e[3] = mat.m10;
	assign e[4] = mat.m11;
	assign e[5] = mat.m12;
	assign e[6] = mat.m20;
	assign e[7] = mat.m21;
	assign e[8] = mat.m22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			dv_vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[2:0], mat_valid};
			dv_vld_s[0] <= vld_q[3];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) begin
				p_s1[2*k]   <= e[PA[k]] * e[PB[k]];
				p_s1[2*k+1] <= e[PC[k]] * e[PD[k]];
			end
			for (int k = 0; k < 3; k++) begin
				r0_s1[k] <= e[k];
				r0_s2[k] <= r0_s1[k];
			end
			for (int k = 0; k < 9; k++) begin
				cof_s2[k] <= {p_s1[2*k][PROD_W-1], p_s1[2*k]}
					- {p_s1[2*k+1][PROD_W-1], p_s1[2*k+1]};
				cof_s3[k] <= cof_s2[k];
				cof_s4[k] <= cof_s3[k];
			end
			for (int k = 0; k < 3; k++) begin
				t_s3[k] <= r0_s2[k] * cof_s2[k];
			end
			// cofactor expansion along row 0
			det_s4 <= DET_W'(t_s3[0]) + DET_W'(t_s3[1]) + DET_W'(t_s3[2]);
		end
	end

	// divider setup: N = 2*|cof|*2^28 + |det|, D = 2*|det|
	logic [DET_W-1:0]  dmag;
	logic [DIV_W-1:0]  dd;
	logic [COF_W-1:0]  cmag [9];
	logic [REM_W-1:0]  nn [9];

	always_comb begin
		dmag = det_s4[DET_W-1] ? DET_W'(-det_s4) : DET_W'(det_s4);
		dd   = {dmag[DMAG_W-1:0], 1'b0};
		for (int l = 0; l < 9; l++) begin
			cmag[l] = cof_s4[(l%3)*3 + l/3][COF_W-1] ? COF_W'(-cof_s4[(l%3)*3 + l/3])
				: COF_W'(cof_s4[(l%3)*3 + l/3]);
			nn[l] = (REM_W'(cmag[l]) << (QSHIFT + 1)) + REM_W'(dmag[DMAG_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_d_s[0]   <= dd;
			dv_det_s[0] <= det_s4;
			dv_sng_s[0] <= (det_s4 == '0);
			for (int l = 0; l < 9; l++) begin
				dv_rem_s[0][l] <= nn[l];
				dv_q_s[0][l]   <= '0;
				dv_ovf_s[0][l] <= (REM_W'(nn[l] >> NDIV) >= REM_W'(dd));
				dv_neg_s[0][l] <= cof_s4[(l%3)*3 + l/3][COF_W-1] ^ det_s4[DET_W-1];
			end
		end
	end

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		localparam int B = NDIV - 1 - k;
		logic [REM_W-1:0] rem_n [9];
		logic             bit_n [9];

		always_comb begin
			for (int l = 0; l < 9; l++) begin
				bit_n[l] = (dv_rem_s[k][l] >> B) >= REM_W'(dv_d_s[k]);
				rem_n[l] = bit_n[l] ? dv_rem_s[k][l] - (REM_W'(dv_d_s[k]) << B)
					: dv_rem_s[k][l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_d_s[k+1]   <= dv_d_s[k];
				dv_det_s[k+1] <= dv_det_s[k];
				dv_sng_s[k+1] <= dv_sng_s[k];
				for (int l = 0; l < 9; l++) begin
					dv_rem_s[k+1][l] <= rem_n[l];
					dv_q_s[k+1][l]   <= dv_q_s[k][l] | (Q_W'(bit_n[l]) << B);
					dv_ovf_s[k+1][l] <= dv_ovf_s[k][l];
					dv_neg_s[k+1][l] <= dv_neg_s[k][l];
				end
			end
		end
	end

	// sign, clip and singular handling
	logic [31:0] res [9];
	logic        sat [9];
	logic        any_sat;
	logic        sng;
	logic [Q_W-1:0] qf;

	always_comb begin
		sng     = dv_sng_s[NDIV];
		any_sat = 1'b0;
		for (int l = 0; l < 9; l++) begin
			qf = dv_q_s[NDIV][l];
			if (dv_neg_s[NDIV][l]) begin
				sat[l] = dv_ovf_s[NDIV][l] || (qf > NEG_MAX);
				res[l] = sat[l] ? 32'h8000_0000 : 32'(-qf);
			end else begin
				sat[l] = dv_ovf_s[NDIV][l] || (qf > POS_MAX);
				res[l] = sat[l] ? 32'h7FFF_FFFF : qf[31:0];
			end
			if (sng) begin
				sat[l] = 1'b0;
				res[l] = '0;
			end
			any_sat = any_sat | sat[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_vld_s[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.inv00       <= res[0];
			out_q.inv01       <= res[1];
			out_q.inv02       <= res[2];
			out_q.inv10       <= res[3];
			out_q.inv11       <= res[4];
			out_q.inv12       <= res[5];
			out_q.inv20       <= res[6];
			out_q.inv21       <= res[7];
			out_q.inv22       <= res[8];
			out_q.determinant <= dv_det_s[NDIV];
			out_q.singular    <= sng;
			out_q.saturated   <= any_sat;
		end
	end

`ifndef SYNTHESIS
	a_sng_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && inv.singular |-> inv.determinant == '0 && !inv.saturated
			&& inv.inv00 == '0 && inv.inv22 == '0)
		else $error("singular result not cleared");
	a_det_nz: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && !inv.singular |-> inv.determinant != '0)
		else $error("nonzero determinant flagged wrong");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		mat_valid && !mat_stall |=> vld_q[0])
		else $error("accepted request lost at entry");
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		mat_stall |=> $stable(dv_vld_s))
		else $error("pipeline moved while frozen");
`endif

endmodule

@@ bench/testbench.sv @@
module testbench;
	import m3inv_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic mat_valid = 1'b0;
	logic mat_stall;
	mat_t mat = '0;
	logic inv_valid;
	logic inv_stall = 1'b0;
	inv_t inv;

	matrix3_inverse_adjugate dut (
		.clk(clk), .arst_n(arst_n),
		.mat_valid(mat_valid), .mat_stall(mat_stall), .mat(mat),
		.inv_valid(inv_valid), .inv_stall(inv_stall), .inv(inv)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	localparam int LATENCY = 39;
	localparam int WATCHDOG_LIMIT = 20000;

	inv_t pending_inverses[$];
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_off = 1'b0;
	int mismatches = 0;
	int results_seen = 0;
	int requests_sent = 0;
	int singular_seen = 0;
	int saturated_seen = 0;
	int quiet_cycles = 0;

	// rounded, saturated Q16.16 quotient of cof*2^28/det, ties away from zero
	function automatic logic signed [31:0] divide_q16(longint cof, longint det,
			ref bit sat);
		logic [63:0] n, d, q;
		bit neg;
		n = (cof < 0 ? -cof : cof);
		n = n << QSHIFT;
		d = (det < 0 ? -det : det);
		q = (2 * n + d) / (2 * d);
		neg = (cof < 0) != (det < 0);
		if (q == 0)
			return 0;
		if (neg) begin
			if (q > 64'd2147483648) begin
				sat = 1'b1;
				return 32'sh8000_0000;
			end
			return -q[31:0];
		end
		if (q > 64'd2147483647) begin
			sat = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		return q[31:0];
	endfunction

	function automatic inv_t invert_matrix(mat_t m);
		longint a[3][3];
		longint cof[3][3];
		longint det;
		logic signed [31:0] q[9];
		bit sat;
		inv_t r;
		a[0][0] = m.m00; a[0][1] = m.m01; a[0][2] = m.m02;
		a[1][0] = m.m10; a[1][1] = m.m11; a[1][2] = m.m12;
		a[2][0] = m.m20; a[2][1] = m.m21; a[2][2] = m.m22;
		det = a[0][0]*a[1][1]*a[2][2] + a[2][0]*a[0][1]*a[1][2]
			+ a[1][0]*a[2][1]*a[0][2] - a[2][0]*a[1][1]*a[0][2]
			- a[0][0]*a[2][1]*a[1][2] - a[1][0]*a[0][1]*a[2][2];
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				cof[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
					- a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
		r = '0;
		sat = 1'b0;
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				q[i*3+j] = divide_q16(cof[j][i], det, sat);
		{r.inv00, r.inv01, r.inv02, r.inv10, r.inv11, r.inv12,
			r.inv20, r.inv21, r.inv22} = {q[0], q[1], q[2], q[3], q[4], q[5],
			q[6], q[7], q[8]};
		r.determinant = det[51:0];
		r.saturated = sat;
		return r;
	endfunction

	// valid stays high after the accepting edge so requests can follow back to back
	task automatic send_matrix(mat_t m);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			mat_valid <= 1'b0;
			@(posedge clk);
		end
		mat_valid <= 1'b1;
		mat <= m;
		pending_inverses.insert(pending_inverses.size(), invert_matrix(m));
		@(posedge clk);
		while (mat_stall)
			@(posedge clk);
		requests_sent++;
	endtask

	task automatic drop_valid();
		mat_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] random_element();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'h1000;
			4: return 16'($urandom_range(64)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic mat_t random_matrix();
		mat_t m;
		logic [15:0] e[9];
		int kind;
		kind = $urandom_range(9);
		for (int i = 0; i < 9; i++)
			e[i] = (kind < 3) ? 16'($urandom) : random_element();
		if (kind == 3) begin
			// repeated row makes it singular
			e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
		end else if (kind == 4) begin
			// near-diagonal with tiny values pushes quotients to the rails
			for (int i = 0; i < 9; i++)
				e[i] = (i % 4 == 0) ? 16'($urandom_range(3)) - 16'd1 : 16'd0;
			e[$urandom_range(8)] = 16'($urandom);
		end
		m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
		return m;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			inv_stall <= hold_off || (stall_pct != 0 && $urandom_range(99) < stall_pct);
			if ((mat_valid && !mat_stall) || (inv_valid && !inv_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > WATCHDOG_LIMIT) begin
				$display("timeout: %0d results outstanding", pending_inverses.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		inv_t want;
		if (arst_n && inv_valid && !inv_stall) begin
			results_seen++;
			if (pending_inverses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected inverse %h", inv);
			end else begin
				want = pending_inverses.pop_front();
				if (want !== inv) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d: expected %h got %h", results_seen,
							want, inv);
				end
				singular_seen += want.singular;
				saturated_seen += want.saturated;
			end
		end
	end

	task automatic test_directed();
		logic [15:0] e[9];
		mat_t m;
		// identity, scaled identity, extremes, singular, walking bits
		send_matrix({16'h1000, 16'h0, 16'h0, 16'h0, 16'h1000, 16'h0, 16'h0, 16'h0,
			16'h1000});
		send_matrix({16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h0,
			16'h8000});
		send_matrix({16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h7FFF, 16'h0, 16'h0, 16'h0,
			16'h7FFF});
		send_matrix({16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0,
			16'h0001});
		send_matrix({16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0,
			16'h0001});
		send_matrix('0);
		send_matrix({9{16'h8000}});
		send_matrix({9{16'h7FFF}});
		send_matrix({16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h7FFF, 16'h7FFF, 16'h8000});
		send_matrix({16'h8000, 16'h7FFF, 16'h0, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h0, 16'h7FFF, 16'h8000});
		// rotation-like, then a diagonal whose inverse does not divide evenly
		send_matrix({16'h0, 16'hF000, 16'h0, 16'h1000, 16'h0, 16'h0, 16'h0, 16'h0,
			16'h1000});
		send_matrix({16'h0003, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0,
			16'h0001});
		for (int b = 0; b < 16; b += 2) begin
			for (int i = 0; i < 9; i++)
				e[i] = (i % 4 == 0) ? (16'h1 << b) : (16'h1 << ((b + i) % 16));
			m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
			send_matrix(m);
			send_matrix(~m);
		end
	endtask

	task automatic test_random(int count, int idle, int stall);
		idle_pct = idle;
		stall_pct = stall;
		repeat (count)
			send_matrix(random_matrix());
		idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_backpressure();
		// receiver holds off long enough for the pipeline to fill
		fork
			begin
				hold_off = 1'b1;
				repeat (120) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				repeat (80) send_matrix(random_matrix());
				drop_valid();
			end
		join
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(400, 0, 0);
		test_random(350, 64, 0);
		test_random(350, 0, 64);
		test_random(350, 26, 26);
		test_backpressure();
		test_random(50, 0, 0);
		drop_valid();
		while (pending_inverses.size() != 0)
			@(posedge clk);
		repeat (LATENCY * 2) @(posedge clk);
		$display("%0d matrices inverted, %0d singular, %0d saturated,",
			requests_sent, singular_seen, saturated_seen);
		$display("under sender idling, receiver stalls and a long hold-off");
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
